>>> design/mhpq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the max-heap priority queue
// Store geometry, command and status codes, the controller states and the
// structs that pass between the controller, the heap memory and the top.
// ---------------------------------------------------------------------------
package mhpq_pkg;

    // Store geometry.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = IDX_W + 2;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 7;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEL_LD,
        ST_INS_RD,
        ST_INS_CMP,
        ST_DEL_RD,
        ST_DEL_CMP,
        ST_TOP_RD,
        ST_TOP_LD,
        ST_DONE
    } state_t;

    // Access to the heap memory: one write port and two read ports.
    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        waddr;
        logic signed [KEY_W-1:0] wdata;
        logic [IDX_W-1:0]        raddr_a;
        logic [IDX_W-1:0]        raddr_b;
    } mem_req_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] rdata_a;
        logic signed [KEY_W-1:0] rdata_b;
    } mem_rsp_t;

    // One result word.
    typedef struct packed {
        status_t                 status;
        logic signed [KEY_W-1:0] removed;
        logic signed [KEY_W-1:0] top;
        logic [COUNT_W-1:0]      count;
    } res_t;

endpackage
`default_nettype wire

>>> design/mhpq_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhpq_ram: heap key store
// Synchronous memory of CAPACITY keys with one write port and two read
// ports; read data is registered and appears in the cycle after the address.
// ---------------------------------------------------------------------------
module mhpq_ram (
    input  wire logic               aclk,
    input  wire mhpq_pkg::mem_req_t req,
    output mhpq_pkg::mem_rsp_t      rsp
);
    import mhpq_pkg::*;

    logic signed [KEY_W-1:0] mem [CAPACITY];

    // Write first in program order; a read of the entry written in the same
    // cycle returns the old key, which the controller never relies on.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rsp.rdata_a <= mem[req.raddr_a];
        rsp.rdata_b <= mem[req.raddr_b];
    end

endmodule
`default_nettype wire

>>> design/mhpq_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhpq_ctrl: heap sequencer
// Runs insert and delete operations against the heap memory. The moving key
// is held in a register while the hole walks up or down the tree, so each
// level costs one read and one write of the memory.
// ---------------------------------------------------------------------------
module mhpq_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0] s_value,
    output mhpq_pkg::mem_req_t                 mem_req,
    input  wire mhpq_pkg::mem_rsp_t            mem_rsp,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output mhpq_pkg::res_t                     res
);
    import mhpq_pkg::*;

    state_t                  state_reg,   state_next;
    logic [CNT_W-1:0]        count_reg,   count_next;
    logic [IDX_W-1:0]        pos_reg,     pos_next;
    logic signed [KEY_W-1:0] key_reg,     key_next;
    status_t                 status_reg,  status_next;
    logic signed [KEY_W-1:0] removed_reg, removed_next;
    logic signed [KEY_W-1:0] top_reg,     top_next;

    logic [IDX_W-1:0]        parent;
    logic [CHILD_W-1:0]      left;
    logic [CHILD_W-1:0]      right;
    logic [CHILD_W-1:0]      fill_ext;
    logic                    pick_right;
    logic [IDX_W-1:0]        best_idx;
    logic signed [KEY_W-1:0] best_key;

    // Tree neighbours of the current hole.
    always_comb begin
        parent     = IDX_W'((pos_reg - IDX_W'(1)) >> 1);
        left       = {1'b0, pos_reg, 1'b1};
        right      = left + CHILD_W'(1);
        fill_ext   = CHILD_W'(count_reg);
        pick_right = (right < fill_ext) && (mem_rsp.rdata_b > mem_rsp.rdata_a);
        best_idx   = pick_right ? right[IDX_W-1:0] : left[IDX_W-1:0];
        best_key   = pick_right ? mem_rsp.rdata_b : mem_rsp.rdata_a;
    end

    // State register and operation registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        pos_reg     <= pos_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        top_reg     <= top_next;
    end

    // Next state, memory accesses and handshakes.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        removed_next  = removed_reg;
        top_next      = top_reg;
        mem_req       = '0;
        s_ready       = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready          = 1'b1;
                mem_req.raddr_a  = '0;
                mem_req.raddr_b  = IDX_W'(count_reg - CNT_W'(1));
                if (s_valid) begin
                    removed_next = '0;
                    status_next  = STAT_OK;
                    if (s_cmd == CMD_INSERT) begin
                        if (count_reg == CNT_W'(CAPACITY)) begin
                            status_next = STAT_FULL;
                            state_next  = ST_TOP_RD;
                        end else begin
                            pos_next   = count_reg[IDX_W-1:0];
                            key_next   = s_value;
                            count_next = count_reg + CNT_W'(1);
                            state_next = ST_INS_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = STAT_EMPTY;
                            top_next    = '0;
                            state_next  = ST_DONE;
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = ST_DEL_LD;
                        end
                    end
                end
            end

            // Root and last entry are back: the last entry becomes the key
            // that sinks from the root.
            ST_DEL_LD: begin
                removed_next = mem_rsp.rdata_a;
                key_next     = mem_rsp.rdata_b;
                pos_next     = '0;
                state_next   = ST_DEL_RD;
            end

            // Sift up: fetch the parent unless the hole has reached the root.
            ST_INS_RD: begin
                if (pos_reg == '0) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pos_reg;
                    mem_req.wdata = key_reg;
                    state_next    = ST_TOP_RD;
                end else begin
                    mem_req.raddr_a = parent;
                    state_next      = ST_INS_CMP;
                end
            end

            // A smaller parent moves down into the hole; otherwise the key
            // settles here.
            ST_INS_CMP: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                if (key_reg > mem_rsp.rdata_a) begin
                    mem_req.wdata = mem_rsp.rdata_a;
                    pos_next      = parent;
                    state_next    = ST_INS_RD;
                end else begin
                    mem_req.wdata = key_reg;
                    state_next    = ST_TOP_RD;
                end
            end

            // Sift down: fetch both children unless the hole is a leaf.
            ST_DEL_RD: begin
                if (left >= fill_ext) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pos_reg;
                    mem_req.wdata = key_reg;
                    state_next    = ST_TOP_RD;
                end else begin
                    mem_req.raddr_a = left[IDX_W-1:0];
                    mem_req.raddr_b = right[IDX_W-1:0];
                    state_next      = ST_DEL_CMP;
                end
            end

            // The larger child, left on a tie, moves up if it beats the key.
            ST_DEL_CMP: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                if (best_key > key_reg) begin
                    mem_req.wdata = best_key;
                    pos_next      = best_idx;
                    state_next    = ST_DEL_RD;
                end else begin
                    mem_req.wdata = key_reg;
                    state_next    = ST_TOP_RD;
                end
            end

            ST_TOP_RD: begin
                mem_req.raddr_a = '0;
                state_next      = ST_TOP_LD;
            end

            ST_TOP_LD: begin
                top_next   = (count_reg != '0) ? mem_rsp.rdata_a : '0;
                state_next = ST_DONE;
            end

            // Hand the result word to the output register.
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.status  = status_reg;
        res.removed = removed_reg;
        res.top     = top_reg;
        res.count   = COUNT_W'(count_reg);
    end

endmodule
`default_nettype wire

>>> design/max_heap_priority_queue_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// max_heap_priority_queue_core: binary max-heap priority queue
// Insert and delete-maximum on signed 32-bit keys held in a heap memory,
// one result word per command word.
// ---------------------------------------------------------------------------
//   channel   direction   fields                          handshake
//   s_        in          cmd, value                      s_valid / s_ready
//   m_        out         status, removed, top, count     m_valid / m_ready
//
// An insert climbs and a delete sinks one level at a time; each level costs
// one read and one write of the single heap memory. After the key settles,
// the root is read back for the top field. A refused insert only reads the
// root; a delete on an empty queue goes straight to the result word.
// Reset empties the queue at once; the memory itself is not cleared.
// A new command word is taken while the previous result word waits in the
// output register; a stalled result holds the sequencer in its final state.
// ---------------------------------------------------------------------------
module max_heap_priority_queue_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_cmd,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0] s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_status,
    output logic signed [mhpq_pkg::KEY_W-1:0]      m_removed,
    output logic signed [mhpq_pkg::KEY_W-1:0]      m_top,
    output logic [mhpq_pkg::COUNT_W-1:0]           m_count
);
    import mhpq_pkg::*;

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;
    logic     res_valid;
    logic     res_ready;
    res_t     res;
    logic     m_valid_reg;
    res_t     out_reg;

    mhpq_ram u_ram (
        .aclk (aclk),
        .req  (mem_req),
        .rsp  (mem_rsp)
    );

    mhpq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_value   (s_value),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: loads a new word when empty or being emptied.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = out_reg.status;
    assign m_removed = out_reg.removed;
    assign m_top     = out_reg.top;
    assign m_count   = out_reg.count;

endmodule
`default_nettype wire

>>> bench/tb_heap_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_heap_checker: result checker of the max-heap priority queue
// Watches both channels, keeps its own copy of the heap, predicts one result
// word per accepted command word and compares the results field by field.
// ---------------------------------------------------------------------------
module tb_heap_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  wire logic                              s_cmd,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0] s_value,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic [1:0]                        m_status,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0] m_removed,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0] m_top,
    input  wire logic [mhpq_pkg::COUNT_W-1:0]      m_count,
    output int                                     outstanding,
    output int                                     fail_count
);

    import mhpq_pkg::*;

    // Predicted heap contents and fill level.
    logic signed [KEY_W-1:0] heap_keys [CAPACITY];
    int                      heap_fill;

    // Result words predicted but not yet seen on the output channel.
    res_t                    awaited_results [$];
    res_t                    oldest_word;
    res_t                    fresh_word;
    int                      mismatches;

    initial begin
        heap_fill   = 0;
        mismatches  = 0;
        outstanding = 0;
        fail_count  = 0;
    end

    // Applies one command word to the predicted heap and returns its result.
    function automatic res_t apply_heap_cmd(input logic cmd,
                                            input logic signed [KEY_W-1:0] key);
        res_t                    r;
        int                      pos;
        int                      lc;
        int                      rc;
        int                      best;
        logic                    settled;
        logic signed [KEY_W-1:0] tmp;
        r.status  = STAT_OK;
        r.removed = '0;
        if (cmd == CMD_INSERT) begin
            if (heap_fill >= CAPACITY) begin
                r.status = STAT_FULL;
            end else begin
                // Append and climb while strictly greater than the parent.
                heap_keys[heap_fill] = key;
                pos = heap_fill;
                heap_fill++;
                while (pos != 0 && heap_keys[pos] > heap_keys[(pos - 1) / 2]) begin
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[(pos - 1) / 2];
                    heap_keys[(pos - 1) / 2] = tmp;
                    pos = (pos - 1) / 2;
                end
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                // Take the root, move the last entry up and let it sink. The
                // left child wins a tie between the children.
                r.removed = heap_keys[0];
                heap_fill--;
                heap_keys[0] = heap_keys[heap_fill];
                pos = 0;
                settled = 1'b0;
                while (!settled) begin
                    lc = 2 * pos + 1;
                    rc = lc + 1;
                    if (lc >= heap_fill) begin
                        settled = 1'b1;
                    end else begin
                        best = lc;
                        if (rc < heap_fill && heap_keys[rc] > heap_keys[lc]) begin
                            best = rc;
                        end
                        if (heap_keys[best] > heap_keys[pos]) begin
                            tmp = heap_keys[pos];
                            heap_keys[pos] = heap_keys[best];
                            heap_keys[best] = tmp;
                            pos = best;
                        end else begin
                            settled = 1'b1;
                        end
                    end
                end
            end
        end
        r.top   = (heap_fill != 0) ? heap_keys[0] : '0;
        r.count = heap_fill[COUNT_W-1:0];
        return r;
    endfunction

    // Compare each accepted result word with the oldest prediction, then
    // predict the result of a command word accepted at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with no prediction waiting");
                    mismatches++;
                end else begin
                    oldest_word = awaited_results.pop_front();
                    if (m_status !== oldest_word.status) begin
                        $error("status: expected %0d, got %0d",
                               oldest_word.status, m_status);
                        mismatches++;
                    end
                    if (m_removed !== oldest_word.removed) begin
                        $error("removed: expected %0d, got %0d",
                               oldest_word.removed, m_removed);
                        mismatches++;
                    end
                    if (m_top !== oldest_word.top) begin
                        $error("top: expected %0d, got %0d", oldest_word.top, m_top);
                        mismatches++;
                    end
                    if (m_count !== oldest_word.count) begin
                        $error("count: expected %0d, got %0d",
                               oldest_word.count, m_count);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                fresh_word      = apply_heap_cmd(s_cmd, s_value);
                awaited_results = {awaited_results, fresh_word};
            end
        end
        outstanding <= awaited_results.size();
        fail_count  <= mismatches;
    end

endmodule
`default_nettype wire

>>> bench/tb_max_heap_priority_queue_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_max_heap_priority_queue_core: testbench of the max-heap priority queue
// Drives a directed run of edge keys, ties and empty deletes, then random
// fill and drain runs that reach a full store, under four idling schemes.
// The checker beside the block predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_max_heap_priority_queue_core;

    import mhpq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WORDS_PER_RUN  = 225;

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_cmd   = CMD_INSERT;
    logic signed [KEY_W-1:0] s_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_status;
    logic signed [KEY_W-1:0] m_removed;
    logic signed [KEY_W-1:0] m_top;
    logic [COUNT_W-1:0]      m_count;
    int                      outstanding;
    int                      fail_count;

    // Percentages of idle sender cycles and stalled receiver cycles.
    int                      idle_pct  = 0;
    int                      stall_pct = 0;

    always #5 aclk = ~aclk;

    max_heap_priority_queue_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_removed (m_removed),
        .m_top     (m_top),
        .m_count   (m_count)
    );

    tb_heap_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_removed   (m_removed),
        .m_top       (m_top),
        .m_count     (m_count),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // Receiver stalls at random.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Presents one command word, after random idle cycles, until accepted.
    task automatic send_word(input logic cmd, input logic signed [KEY_W-1:0] key);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_value <= key;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Holds the sender off until every predicted result word has arrived.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Keys: edge values, a narrow band that forces ties, and full-width noise.
    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0:       k = 32'sh7fffffff;
            1:       k = 32'sh80000000;
            2, 3, 4: k = int'($urandom_range(0, 8)) - 4;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // Stimulus and verdict.
    initial begin : stimulus
        int   run;
        int   sent;
        int   seg_len;
        int   ins_pct;
        logic cmd;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: delete on empty, removal of the last entry, edge
        // keys, equal keys and a full drain past empty.
        send_word(CMD_DELETE, $urandom);
        send_word(CMD_INSERT, 32'sh7fffffff);
        send_word(CMD_DELETE, $urandom);
        send_word(CMD_INSERT, 32'sh80000000);
        send_word(CMD_INSERT, -32'sd1);
        send_word(CMD_INSERT, 32'sd0);
        send_word(CMD_INSERT, 32'sh7fffffff);
        send_word(CMD_INSERT, 32'sd1);
        send_word(CMD_INSERT, 32'sd5);
        send_word(CMD_INSERT, 32'sd5);
        send_word(CMD_INSERT, 32'sd5);
        send_word(CMD_INSERT, 32'sh55555555);
        send_word(CMD_INSERT, 32'shaaaaaaaa);
        repeat (11) send_word(CMD_DELETE, $urandom);
        wait_for_drain();

        // Random part: fill, mixed and drain segments under each idling
        // scheme. Each run opens with a fill that reaches a full store.
        for (run = 0; run < 4; run++) begin
            case (run)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 51; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 51; end
                default: begin idle_pct = 26; stall_pct <= 26; end
            endcase
            sent = 0;
            seg_len = 100;
            ins_pct = 95;
            while (sent < WORDS_PER_RUN) begin
                for (int i = 0; i < seg_len && sent < WORDS_PER_RUN; i++) begin
                    cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
                    send_word(cmd, pick_key());
                    sent++;
                end
                seg_len = $urandom_range(30, 90);
                case ($urandom_range(0, 2))
                    0:       ins_pct = 90;
                    1:       ins_pct = 50;
                    default: ins_pct = 15;
                endcase
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: ends the run after a long stretch with no word accepted.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
